@@ rtl/ordered_list_engine_assert.svh @@
// ----------------------------------------------------------------------------
// ordered_list_engine assertion macros
// Concurrent check wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define OLE_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ordered_list_engine: check failed");
`define OLE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ordered_list_engine: check failed");
`else
`define OLE_ASSERT_IMP(lbl, pre, post)
`define OLE_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and codes of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DefCapacity = 64;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_REVERSE = 3'd3;
  localparam logic [2:0] OP_SORT    = 3'd4;
  localparam logic [2:0] OP_GET     = 3'd5;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         position;
    logic signed [63:0] entry_value;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic signed [63:0] read_value;
    logic [6:0]         entry_count;
  } out_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_APPEND,
    CM_INSERT,
    CM_DELETE,
    CM_REVERSE,
    CM_SORT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t  mode;
    logic        parity;
    logic [5:0]  pos;
    logic [63:0] value;
  } cell_cmd_t;

endpackage

@@ rtl/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine
// Append, get, insert and delete: result strobe registered in the cycle after the
// transfer, next transfer accepted the following cycle (one item per cycle).
// Reverse and sort: count odd-even transposition rounds over the cell chain,
// busy while the rounds run, result strobe in the cycle after the last round.
// Synchronous active-low reset empties the list; entry contents are not reset.
// ----------------------------------------------------------------------------
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  `include "ordered_list_engine_assert.svh"

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int XW   = (CntW > 6) ? CntW : 6;
  localparam logic [XW-1:0] CapX = XW'(CAPACITY);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t          state_r;
  logic [CntW-1:0] cnt_r, round_r;
  logic            parity_r, sort_r;
  logic            out_valid_r;
  out_t            out_r;

  cell_cmd_t       cmd;
  logic            accept;
  logic [XW-1:0]   cnt_x, pos_x;
  logic [63:0]     ent_w [CAPACITY];
  logic            gt_w  [CAPACITY];
  logic [63:0]     rd_w  [CAPACITY];
  logic [63:0]     rd_any;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r == S_RUN);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cnt_x     = XW'(cnt_r);
  assign pos_x     = XW'(in_item.position);

  always_comb begin
    cmd.mode   = CM_HOLD;
    cmd.parity = parity_r;
    cmd.pos    = in_item.position;
    cmd.value  = in_item.entry_value;
    if (state_r == S_RUN) begin
      cmd.mode = sort_r ? CM_SORT : CM_REVERSE;
    end else if (accept) begin
      case (in_item.operation)
        OP_APPEND: if (cnt_x < CapX) cmd.mode = CM_APPEND;
        OP_INSERT: if (cnt_x < CapX && pos_x <= cnt_x) cmd.mode = CM_INSERT;
        OP_DELETE: if (pos_x < cnt_x) cmd.mode = CM_DELETE;
        default:   cmd.mode = CM_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [63:0] left_v, right_v;
    logic        left_gt;
    if (g == 0) begin : g_first
      assign left_v  = 64'd0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_v  = ent_w[g-1];
      assign left_gt = gt_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = 64'd0;
    end else begin : g_body
      assign right_v = ent_w[g+1];
    end
    ole_cell #(.Index(g), .CntW(CntW)) u_cell (
      .clk      (clk),
      .cmd_i    (cmd),
      .cnt_i    (cnt_r),
      .left_i   (left_v),
      .left_gt_i(left_gt),
      .right_i  (right_v),
      .ent_o    (ent_w[g]),
      .gt_o     (gt_w[g]),
      .rd_o     (rd_w[g])
    );
  end

  always_comb begin
    rd_any = 64'd0;
    for (int k = 0; k < CAPACITY; k++) rd_any = rd_any | rd_w[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      round_r     <= '0;
      parity_r    <= 1'b0;
      sort_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_r.ok         <= 1'b0;
            out_r.read_value <= '0;
            out_r.entry_count <= 7'(cnt_r);
            round_r  <= '0;
            parity_r <= 1'b0;
            sort_r   <= (in_item.operation == OP_SORT);
            case (cmd.mode)
              CM_APPEND, CM_INSERT: begin
                cnt_r             <= cnt_r + 1'b1;
                out_r.ok          <= 1'b1;
                out_r.entry_count <= 7'(cnt_r + 1'b1);
              end
              CM_DELETE: begin
                cnt_r             <= cnt_r - 1'b1;
                out_r.ok          <= 1'b1;
                out_r.entry_count <= 7'(cnt_r - 1'b1);
              end
              default: ;
            endcase
            if ((in_item.operation == OP_REVERSE || in_item.operation == OP_SORT)
                && cnt_r != '0) begin
              state_r <= S_RUN;
            end else begin
              out_valid_r <= 1'b1;
              if (in_item.operation == OP_GET && pos_x < cnt_x) begin
                out_r.ok         <= 1'b1;
                out_r.read_value <= rd_any;
              end
            end
          end
        end
        S_RUN: begin
          round_r  <= round_r + 1'b1;
          parity_r <= !parity_r;
          if (round_r == cnt_r - 1'b1) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_r.ok    <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `OLE_ASSERT_IMP(a_no_strobe_busy, out_valid, !busy)
  `OLE_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_x <= CapX)
  `OLE_ASSERT_NEXT(a_run_on_sort, accept && (in_item.operation == OP_SORT || in_item.operation == OP_REVERSE) && cnt_r != '0, busy)
  `OLE_ASSERT_NEXT(a_single_op, accept && in_item.operation != OP_SORT && in_item.operation != OP_REVERSE, out_valid)

endmodule

@@ rtl/ole_cell.sv @@
// ----------------------------------------------------------------------------
// ole_cell
// One list entry; shifts, swaps with a neighbour or loads the command value.
// ----------------------------------------------------------------------------
module ole_cell
  import ole_pkg::*;
#(
  parameter int Index = 0,
  parameter int CntW  = 7
) (
  input  logic            clk,
  input  cell_cmd_t       cmd_i,
  input  logic [CntW-1:0] cnt_i,
  input  logic [63:0]     left_i,
  input  logic            left_gt_i,
  input  logic [63:0]     right_i,
  output logic [63:0]     ent_o,
  output logic            gt_o,
  output logic [63:0]     rd_o
);

  localparam int XW = (CntW > 6) ? CntW : 6;
  localparam logic [XW:0] IdxX = (XW+1)'(Index);
  localparam logic [XW:0] IdxP1 = (XW+1)'(Index + 1);
  localparam logic ParBit = 1'((Index % 2));

  logic [63:0] ent_r, ent_nxt;
  logic [XW:0] cnt_x, pos_x;

  assign cnt_x = (XW+1)'(cnt_i);
  assign pos_x = (XW+1)'(cmd_i.pos);
  assign gt_o  = $signed(ent_r) > $signed(right_i);
  assign ent_o = ent_r;
  assign rd_o  = (IdxX == pos_x) ? ent_r : 64'd0;

  always_comb begin
    ent_nxt = ent_r;
    case (cmd_i.mode)
      CM_APPEND: begin
        if (IdxX == cnt_x) ent_nxt = cmd_i.value;
      end
      CM_INSERT: begin
        if (IdxX == pos_x) ent_nxt = cmd_i.value;
        else if (IdxX > pos_x && IdxX <= cnt_x) ent_nxt = left_i;
      end
      CM_DELETE: begin
        if (IdxX >= pos_x && IdxP1 < cnt_x) ent_nxt = right_i;
      end
      CM_REVERSE, CM_SORT: begin
        if (ParBit == cmd_i.parity) begin
          if (IdxP1 < cnt_x && (cmd_i.mode == CM_REVERSE || gt_o)) ent_nxt = right_i;
        end else begin
          if (Index >= 1 && IdxX < cnt_x && (cmd_i.mode == CM_REVERSE || left_gt_i))
            ent_nxt = left_i;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
